>>> rtl/core/fbc_pkg.sv
`timescale 1ns / 1ps

package fbc_pkg;

    localparam int PLANE_COUNT_DEF   = 6;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int IDX_W  = 3;
    localparam int NRM_W  = 18;
    localparam int OFF_W  = 32;
    localparam int CRD_W  = 32;
    localparam int HLF_W  = 31;
    localparam int COV_W  = 2;

    // Exact products and sums.
    localparam int PD_W   = NRM_W + CRD_W;   // signed n * c
    localparam int PR_W   = NRM_W + HLF_W;   // unsigned |n| * h
    localparam int ACC_W  = 64;

    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 8;

    localparam logic       KIND_LOAD = 1'b0;
    localparam logic       KIND_TEST = 1'b1;

    localparam logic [COV_W-1:0] COV_OUTSIDE = 2'd0;
    localparam logic [COV_W-1:0] COV_PARTIAL = 2'd1;
    localparam logic [COV_W-1:0] COV_FULL    = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        idx;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [OFF_W-1:0] off;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic signed [CRD_W-1:0] cz;
        logic [HLF_W-1:0]        hx;
        logic [HLF_W-1:0]        hy;
        logic [HLF_W-1:0]        hz;
        logic [COV_W-1:0]        cov;
    } item_t;

endpackage

>>> rtl/core/fbc_cell.sv
`timescale 1ns / 1ps

module fbc_cell #(
    parameter int CELL_INDEX    = 0,
    parameter int FRACTION_BITS = fbc_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  fbc_pkg::item_t in_item,
    output logic          out_valid,
    output fbc_pkg::item_t out_item
);
    import fbc_pkg::*;

    // Stored plane of this slot; undefined until loaded.
    logic signed [NRM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [OFF_W-1:0] off_reg;

    // Stage 1: products.
    logic                    s1_valid_reg;
    item_t                   s1_item_reg;
    logic signed [PD_W-1:0]  s1_pdx_reg, s1_pdy_reg, s1_pdz_reg;
    logic [PR_W-1:0]         s1_prx_reg, s1_pry_reg, s1_prz_reg;
    logic signed [OFF_W-1:0] s1_off_reg;

    // Stage 2: distance and radius.
    logic                    s2_valid_reg;
    item_t                   s2_item_reg;
    logic signed [ACC_W-1:0] s2_d_reg;
    logic signed [ACC_W-1:0] s2_r_reg;

    // Stage 3: updated classification.
    logic                    s3_valid_reg;
    item_t                   s3_item_reg;
    item_t                   s3_item_next;

    logic                    load_hit;
    logic [NRM_W-1:0]        ax, ay, az;
    logic signed [ACC_W-1:0] d_next, r_next, hi_sum, lo_sum;
    logic [COV_W-1:0]        cov_next;

    assign load_hit = in_valid && (in_item.kind == KIND_LOAD) && (CELL_INDEX < 8)
                      && (in_item.idx == IDX_W'(CELL_INDEX));

    always_comb
    begin
        ax = nx_reg[NRM_W-1] ? NRM_W'(-nx_reg) : NRM_W'(nx_reg);
        ay = ny_reg[NRM_W-1] ? NRM_W'(-ny_reg) : NRM_W'(ny_reg);
        az = nz_reg[NRM_W-1] ? NRM_W'(-nz_reg) : NRM_W'(nz_reg);
    end

    always_comb
    begin
        d_next = (ACC_W'(s1_off_reg) <<< FRACTION_BITS) + ACC_W'(s1_pdx_reg)
                 + ACC_W'(s1_pdy_reg) + ACC_W'(s1_pdz_reg);
        r_next = ACC_W'(s1_prx_reg) + ACC_W'(s1_pry_reg) + ACC_W'(s1_prz_reg);
    end

    always_comb
    begin
        hi_sum   = s2_d_reg + s2_r_reg;
        lo_sum   = s2_d_reg - s2_r_reg;
        cov_next = s2_item_reg.cov;
        if (s2_item_reg.cov != COV_OUTSIDE)
        begin
            if (hi_sum < 0)
                cov_next = COV_OUTSIDE;
            else if (lo_sum < 0)
                cov_next = COV_PARTIAL;
        end
    end

    always_comb
    begin
        s3_item_next     = s2_item_reg;
        s3_item_next.cov = cov_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && load_hit)
        begin
            nx_reg  <= in_item.nx;
            ny_reg  <= in_item.ny;
            nz_reg  <= in_item.nz;
            off_reg <= in_item.off;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= in_item;
            s1_pdx_reg  <= nx_reg * in_item.cx;
            s1_pdy_reg  <= ny_reg * in_item.cy;
            s1_pdz_reg  <= nz_reg * in_item.cz;
            s1_prx_reg  <= ax * in_item.hx;
            s1_pry_reg  <= ay * in_item.hy;
            s1_prz_reg  <= az * in_item.hz;
            s1_off_reg  <= off_reg;

            s2_item_reg <= s1_item_reg;
            s2_d_reg    <= d_next;
            s2_r_reg    <= r_next;

            s3_item_reg <= s3_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

>>> rtl/core/frustum_box_classifier.sv
`timescale 1ns / 1ps

// Frustum box classifier. Every transfer on the input stream is either a plane
// load (tuser low), which stores one plane in the slot given by plane_index and
// produces no result, or a box test (tuser high), which produces one result
// with the coverage (outside, partly inside, fully inside) of the box against
// all stored planes and a visible flag. The planes sit in a chain of
// PLANE_COUNT identical cells, one plane per cell, and every item walks down
// the chain, so loads and tests always take effect in the order they arrived.
// Each cell works on an item in stages (products, sums, compare); a test
// result passes through every cell and then the output register. The chain
// accepts one item every cycle while the output is drained, and the whole
// chain stalls only while a result sits unread in the output register.
// Load every plane slot before the first test; a load whose plane_index is not
// below PLANE_COUNT is ignored.
module frustum_box_classifier #(
    parameter int PLANE_COUNT   = fbc_pkg::PLANE_COUNT_DEF,
    parameter int FRACTION_BITS = fbc_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: plane_index, normal_x, normal_y, normal_z, plane_offset,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero fill.
    input  logic [fbc_pkg::IN_DATA_W-1:0]     s_tdata,
    // Bit 0: kind.
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: coverage (2 bits), visible (1 bit), zero fill.
    output logic [fbc_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import fbc_pkg::*;

    logic                  adv;
    item_t                 in_item;
    logic                  chain_valid [PLANE_COUNT+1];
    item_t                 chain_item  [PLANE_COUNT+1];

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [COV_W-1:0]      cov_reg;
    logic                  vis_reg;

    // The chain moves whenever the output register is free or being emptied.
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        in_item      = '0;
        in_item.kind = s_tuser;
        in_item.idx  = s_tdata[2:0];
        in_item.nx   = s_tdata[20:3];
        in_item.ny   = s_tdata[38:21];
        in_item.nz   = s_tdata[56:39];
        in_item.off  = s_tdata[88:57];
        in_item.cx   = s_tdata[120:89];
        in_item.cy   = s_tdata[152:121];
        in_item.cz   = s_tdata[184:153];
        in_item.hx   = s_tdata[215:185];
        in_item.hy   = s_tdata[246:216];
        in_item.hz   = s_tdata[277:247];
        // A box starts as fully inside; each plane can only demote it.
        in_item.cov  = COV_FULL;
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_item[0]  = in_item;

    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_cell
        fbc_cell #(
            .CELL_INDEX    (g),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // Loads leave the chain silently; only tests reach the output register.
    assign m_tvalid_next = chain_valid[PLANE_COUNT]
                           && (chain_item[PLANE_COUNT].kind == KIND_TEST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cov_reg <= chain_item[PLANE_COUNT].cov;
            vis_reg <= (chain_item[PLANE_COUNT].cov != COV_OUTSIDE);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - COV_W - 1){1'b0}}, vis_reg, cov_reg};

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the frustum box classifier. A behavioral model of the six
// plane slots classifies every accepted box and queues the expected verdict.
// Each transfer on the result stream is checked against the oldest queued
// verdict.
module tb;
    import fbc_pkg::*;

    localparam int  ONE         = 1 << FRACTION_BITS_DEF;  // 1.0 in Q16.16 and Q2.16
    localparam int  CYCLE_LIMIT = 200000;
    // Drain time after the last verdict: the plane cell stages plus slack.
    localparam int  DRAIN_CYCLES = 3 * PLANE_COUNT_DEF + 10;

    typedef struct packed {
        logic [COV_W-1:0] coverage;
        logic             visible;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // Model copy of the plane slots.
    logic signed [NRM_W-1:0] slot_normal [PLANE_COUNT_DEF][3];
    logic signed [OFF_W-1:0] slot_offset [PLANE_COUNT_DEF];

    verdict_t pending_verdicts [$];

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;      // cycles the result side still holds m_tready low

    frustum_box_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frustum_box_classifier regression: fail");
            $finish;
        end
    end

    // Result side. A pending hold-off wins over the random idling, and it is
    // counted down here so that it runs on its own while the sender keeps going.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result transfer is matched against the oldest queued verdict.
    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result transfer, m_tdata = 0x%0h", m_tdata);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[1:0] !== want.coverage) begin
                    $error("coverage: expected %0d, got %0d", want.coverage, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[2] !== want.visible) begin
                    $error("visible: expected %0d, got %0d", want.visible, m_tdata[2]);
                    error_count++;
                end
            end
        end
    end

    // Box against every slot in order, with exact 64-bit sums. The first plane
    // that has the whole box behind it decides the box is outside.
    function automatic logic [COV_W-1:0] classify_box(input item_t it);
        longint center [3];
        longint half [3];
        longint distance;
        longint radius;
        longint nrm;
        logic [COV_W-1:0] cov;
        center[0] = longint'(it.cx);
        center[1] = longint'(it.cy);
        center[2] = longint'(it.cz);
        half[0]   = longint'(it.hx);
        half[1]   = longint'(it.hy);
        half[2]   = longint'(it.hz);
        cov = COV_FULL;
        for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
            distance = longint'(slot_offset[p]) * (longint'(1) << FRACTION_BITS_DEF);
            radius   = 0;
            for (int k = 0; k < 3; k++) begin
                nrm      = longint'(slot_normal[p][k]);
                distance = distance + nrm * center[k];
                radius   = radius + (nrm < 0 ? -nrm : nrm) * half[k];
            end
            if (distance + radius < 0)
                return COV_OUTSIDE;
            if (distance - radius < 0)
                cov = COV_PARTIAL;
        end
        return cov;
    endfunction

    function automatic item_t plane_item(input logic [IDX_W-1:0] idx,
                                         input logic signed [NRM_W-1:0] nx,
                                         input logic signed [NRM_W-1:0] ny,
                                         input logic signed [NRM_W-1:0] nz,
                                         input logic signed [OFF_W-1:0] off);
        item_t it;
        it      = '0;
        it.kind = KIND_LOAD;
        it.idx  = idx;
        it.nx   = nx;
        it.ny   = ny;
        it.nz   = nz;
        it.off  = off;
        return it;
    endfunction

    // Slot s bounds one axis (s / 2) from one side (s % 2): inside when the
    // coordinate lies within +-extent.
    function automatic item_t axis_plane(input int slot, input logic signed [OFF_W-1:0] extent);
        logic signed [NRM_W-1:0] n [3];
        n = '{default: '0};
        n[slot / 2] = (slot % 2 == 0) ? NRM_W'(ONE) : NRM_W'(-ONE);
        return plane_item(IDX_W'(slot), n[0], n[1], n[2], extent);
    endfunction

    function automatic item_t box_item(input logic signed [CRD_W-1:0] cx,
                                       input logic signed [CRD_W-1:0] cy,
                                       input logic signed [CRD_W-1:0] cz,
                                       input logic [HLF_W-1:0] hx,
                                       input logic [HLF_W-1:0] hy,
                                       input logic [HLF_W-1:0] hz);
        item_t it;
        it      = '0;
        it.kind = KIND_TEST;
        it.cx   = cx;
        it.cy   = cy;
        it.cz   = cz;
        it.hx   = hx;
        it.hy   = hy;
        it.hz   = hz;
        return it;
    endfunction

    // Offers one item, idling first at the current rate, and updates the model
    // once the transfer is taken. tvalid stays high on return so that back to
    // back items go out without a gap.
    task automatic send_item(input item_t it);
        verdict_t v;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b00, it.hz, it.hy, it.hx, it.cz, it.cy, it.cx,
                     it.off, it.nz, it.ny, it.nx, it.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.kind == KIND_LOAD) begin
            if (it.idx < PLANE_COUNT_DEF) begin
                slot_normal[it.idx][0] = it.nx;
                slot_normal[it.idx][1] = it.ny;
                slot_normal[it.idx][2] = it.nz;
                slot_offset[it.idx]    = it.off;
            end
        end else begin
            v.coverage = classify_box(it);
            v.visible  = (v.coverage != COV_OUTSIDE);
            pending_verdicts.push_back(v);
        end
    endtask

    // A cube frustum of +-10 units, plus loads to the two slot numbers past the
    // end, which must leave every slot alone.
    task automatic test_plane_loads();
        for (int s = 0; s < PLANE_COUNT_DEF; s++)
            send_item(axis_plane(s, 10 * ONE));
        send_item(plane_item(3'd6, NRM_W'(-ONE), NRM_W'(-ONE), NRM_W'(-ONE), -32'sd1));
        send_item(plane_item(3'd7, 18'sh20000, 18'sh1ffff, 18'sh20000, 32'sh80000000));
    endtask

    task automatic test_directed_boxes();
        send_item(box_item(0, 0, 0, HLF_W'(ONE), HLF_W'(ONE), HLF_W'(ONE)));  // well inside
        send_item(box_item(9 * ONE, 0, 0, HLF_W'(2 * ONE), 0, 0));            // straddles +x
        send_item(box_item(20 * ONE, 0, 0, HLF_W'(ONE), HLF_W'(ONE), HLF_W'(ONE))); // beyond +x
        // Box touches the plane from outside: d + r is exactly zero, so not
        // outside, but d - r is negative.
        send_item(box_item(12 * ONE, 0, 0, HLF_W'(2 * ONE), 0, 0));
        // Box touches the plane from inside: d - r is exactly zero, still full.
        send_item(box_item(8 * ONE, 0, 0, HLF_W'(2 * ONE), 0, 0));
        send_item(box_item(0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        send_item(box_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0));
        send_item(box_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0));
    endtask

    // Normal components beyond unit length are used as their bits say; offsets
    // at both ends of their range.
    task automatic test_extreme_planes();
        send_item(plane_item(3'd0, 18'sh20000, 18'sh1ffff, NRM_W'(-ONE), 32'sh7fffffff));
        send_item(plane_item(3'd1, NRM_W'(ONE), 0, 0, 32'sh80000000));
        send_item(box_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        send_item(box_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        send_item(box_item(32'sh80000000, 32'sh7fffffff, 0, 0, 31'h7fffffff, 0));
    endtask

    // Mostly boxes scattered around a random axis-aligned frustum, so that all three
    // verdicts come up often; the rest reload planes (axis, oblique or raw
    // bits, some to missing slots) and throw raw-bit boxes.
    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        item_t it;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < PLANE_COUNT_DEF; s++)
            send_item(axis_plane(s, $urandom_range(1, 200 * ONE)));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            it   = box_item($urandom(), $urandom(), $urandom(),
                            HLF_W'($urandom()), HLF_W'($urandom()), HLF_W'($urandom()));
            it.idx = IDX_W'($urandom());
            it.nx  = NRM_W'($urandom());
            it.ny  = NRM_W'($urandom());
            it.nz  = NRM_W'($urandom());
            it.off = $urandom();
            if (pick < 6) begin
                it = axis_plane(int'($urandom_range(PLANE_COUNT_DEF - 1)),
                                $urandom_range(1, 200 * ONE));
            end else if (pick < 9) begin
                it.kind = KIND_LOAD;
                it.nx   = NRM_W'(int'($urandom_range(2 * ONE)) - ONE);
                it.ny   = NRM_W'(int'($urandom_range(2 * ONE)) - ONE);
                it.nz   = NRM_W'(int'($urandom_range(2 * ONE)) - ONE);
                it.off  = int'($urandom_range(400 * ONE)) - 200 * ONE;
            end else if (pick < 11) begin
                it.kind = KIND_LOAD;    // raw bits, slot numbers 6 and 7 included
            end else if (pick < 85) begin
                it.cx = int'($urandom_range(500 * ONE)) - 250 * ONE;
                it.cy = int'($urandom_range(500 * ONE)) - 250 * ONE;
                it.cz = int'($urandom_range(500 * ONE)) - 250 * ONE;
                it.hx = HLF_W'($urandom_range(40 * ONE));
                it.hy = HLF_W'($urandom_range(40 * ONE));
                it.hz = HLF_W'($urandom_range(40 * ONE));
            end else if (pick < 92) begin
                it.hx = ($urandom_range(1) == 0) ? 31'h0 : 31'h7fffffff;
                it.hy = ($urandom_range(1) == 0) ? 31'h0 : 31'h7fffffff;
                it.hz = ($urandom_range(1) == 0) ? 31'h0 : 31'h7fffffff;
            end
            send_item(it);
        end
    endtask

    // The result side stops for a long stretch while boxes keep coming at full
    // rate, so the plane chain fills and s_tready must drop.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 300;
        for (int n = 0; n < 50; n++)
            send_item(box_item(int'($urandom_range(500 * ONE)) - 250 * ONE,
                               int'($urandom_range(500 * ONE)) - 250 * ONE,
                               int'($urandom_range(500 * ONE)) - 250 * ONE,
                               HLF_W'($urandom_range(40 * ONE)),
                               HLF_W'($urandom_range(40 * ONE)),
                               HLF_W'($urandom_range(40 * ONE))));
    endtask

    initial begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        hold_left     = 0;
        send_idle_pct = 30;
        recv_idle_pct = 73;
        slot_normal   = '{default: '{default: '0}};
        slot_offset   = '{default: '0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plane_loads();
        test_directed_boxes();
        test_extreme_planes();
        test_random_traffic(270, 30, 73);
        test_random_traffic(270, 73, 30);
        test_output_backpressure();
        test_random_traffic(270, 0, 0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("frustum_box_classifier regression: pass");
        else
            $display("frustum_box_classifier regression: fail");
        $finish;
    end

endmodule
